/* hdl/cps_pkg.sv */
// Package for the contour polyline simplifier: field widths, register
// indexes, reset values and the contour phase type.
// No dependencies; imported by the unit and its checker.
package cps_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int KEPT_W     = 13;
  localparam int MAX_VERTICES = 4096;

  localparam logic [KEPT_W-1:0] KEPT_MAX = KEPT_W'(MAX_VERTICES);

  localparam logic [CFG_IDX_W-1:0] CFG_COS_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH    = 1'b1;

  localparam logic [CFG_W-1:0] COS_THRESHOLD_RST = 16'd31130;
  localparam logic [CFG_W-1:0] MIN_LENGTH_RST    = 16'd0;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_RUN    = 2'd2
  } phase_t;

endpackage

/* hdl/contour_polyline_simplifier_unit.sv */
// A first vertex's result is registered in ST_EMIT_FIRST. A tested vertex passes ST_VISIT,
// ST_MUL (a sequence of steps on one shared 34x34 multiplier) and ST_DEC; its kept point,
// if any, is registered in ST_EMIT_PREV. The unit takes no new vertex until it is through
// with the last one; a last vertex also replays the first vertex and ends the contour. A
// waiting result that is stalled holds the unit longer. Reset: rst_n is synchronous, active
// low; it restores the register defaults and waits for the first vertex of a contour.
module contour_polyline_simplifier_unit
  import cps_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [COORD_W-1:0]   in_x_coord,
  input  logic signed [COORD_W-1:0]   in_y_coord,
  input  logic                        in_last_vertex,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [COORD_W-1:0]   out_x,
  output logic signed [COORD_W-1:0]   out_y,
  output logic                        out_contour_done,
  output logic        [KEPT_W-1:0]    out_kept_count,
  input  logic                        cfg_we,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EMIT_FIRST, ST_VISIT, ST_MUL, ST_DEC, ST_EMIT_PREV, ST_POST, ST_EMIT_END
  } state_t;

  typedef enum logic [3:0] {
    SP_CXX, SP_CYY, SP_DXX, SP_DYY, SP_MM, SP_DOTX, SP_DOTY, SP_ADOT,
    SP_TT, SP_TTLD, SP_RLO, SP_RHI
  } step_t;

  state_t state_r;
  step_t  step_r, step_nxt;
  phase_t phase_r;

  logic [CFG_W-1:0] cos_r, minlen_r;
  logic signed [COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [COORD_W-1:0] vx_r, vy_r;
  logic signed [DIFF_W-1:0]  dir_x_r, dir_y_r;
  logic cur_last_r, replay_r;
  logic [KEPT_W-1:0] kept_r;

  logic [33:0] lc_r, ld_r;
  logic [31:0] mm_r;
  logic signed [34:0] dot_r;
  logic [65:0] left_r;
  logic [62:0] r1_r;
  logic signed [97:0] acc_r, acc_nxt;

  logic signed [DIFF_W-1:0] cx, cy, nx, ny;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [97:0] addend;
  logic accum, shift_hi;
  logic [34:0] dot_abs;
  logic [96:0] left_sh;
  logic cos_hit, merge, slot_free, emit_now;
  logic [KEPT_W-1:0] kept_inc;

  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign emit_now  = slot_free && (state_r == ST_EMIT_FIRST || state_r == ST_EMIT_PREV ||
                                   state_r == ST_EMIT_END);

  assign cx = {vx_r[COORD_W-1], vx_r} - {prev_x_r[COORD_W-1], prev_x_r};
  assign cy = {vy_r[COORD_W-1], vy_r} - {prev_y_r[COORD_W-1], prev_y_r};
  assign nx = {vx_r[COORD_W-1], vx_r} - {first_x_r[COORD_W-1], first_x_r};
  assign ny = {vy_r[COORD_W-1], vy_r} - {first_y_r[COORD_W-1], first_y_r};

  assign dot_abs  = acc_r[34] ? (35'd0 - acc_r[34:0]) : acc_r[34:0];
  assign kept_inc = (kept_r < KEPT_MAX) ? kept_r + 1'b1 : kept_r;

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    accum    = 1'b0;
    shift_hi = 1'b0;
    step_nxt = step_r;
    unique case (step_r)
      SP_CXX: begin
        mul_a = 34'(cx); mul_b = 34'(cx); step_nxt = SP_CYY;
      end
      SP_CYY: begin
        mul_a = 34'(cy); mul_b = 34'(cy); accum = 1'b1; step_nxt = SP_DXX;
      end
      SP_DXX: begin
        mul_a = 34'(dir_x_r); mul_b = 34'(dir_x_r); step_nxt = SP_DYY;
      end
      SP_DYY: begin
        mul_a = 34'(dir_y_r); mul_b = 34'(dir_y_r); accum = 1'b1; step_nxt = SP_MM;
      end
      SP_MM: begin
        mul_a = {18'd0, minlen_r}; mul_b = {18'd0, minlen_r}; step_nxt = SP_DOTX;
      end
      SP_DOTX: begin
        mul_a = 34'(dir_x_r); mul_b = 34'(cx); step_nxt = SP_DOTY;
      end
      SP_DOTY: begin
        mul_a = 34'(dir_y_r); mul_b = 34'(cy); accum = 1'b1; step_nxt = SP_ADOT;
      end
      SP_ADOT: begin
        mul_a = dot_abs[33:0]; mul_b = dot_abs[33:0]; step_nxt = SP_TT;
      end
      SP_TT: begin
        mul_a = 34'(signed'(cos_r)); mul_b = 34'(signed'(cos_r)); step_nxt = SP_TTLD;
      end
      SP_TTLD: begin
        mul_a = acc_r[33:0]; mul_b = ld_r; step_nxt = SP_RLO;
      end
      SP_RLO: begin
        mul_a = {2'd0, acc_r[31:0]}; mul_b = lc_r; step_nxt = SP_RHI;
      end
      SP_RHI: begin
        mul_a = {3'd0, r1_r[62:32]}; mul_b = lc_r; accum = 1'b1; shift_hi = 1'b1;
        step_nxt = SP_CXX;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign addend  = shift_hi ? ({{30{mul_p[67]}}, mul_p} <<< 32) : {{30{mul_p[67]}}, mul_p};
  assign acc_nxt = (accum ? acc_r : 98'sd0) + addend;

  // The cosine test compares dot^2 * 2^30 against t^2 * |dir|^2 * |seg|^2.
  assign left_sh = {1'b0, left_r, 30'd0};
  always_comb begin
    if (!cos_r[CFG_W-1]) begin
      cos_hit = !dot_r[34] && (dot_r != 35'sd0) && (left_sh > acc_r[96:0]);
    end else begin
      cos_hit = !dot_r[34] || (left_sh < acc_r[96:0]);
    end
    merge = (ld_r == 34'd0) || (lc_r == 34'd0) || (lc_r < {2'd0, mm_r}) || cos_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= SP_CXX;
      phase_r    <= PH_FIRST;
      kept_r     <= '0;
      out_valid  <= 1'b0;
      cos_r      <= COS_THRESHOLD_RST;
      minlen_r   <= MIN_LENGTH_RST;
      first_x_r  <= '0;
      first_y_r  <= '0;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      dir_x_r    <= '0;
      dir_y_r    <= '0;
      cur_last_r <= 1'b0;
      replay_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COS_THRESHOLD: cos_r    <= cfg_wdata;
          CFG_MIN_LENGTH:    minlen_r <= cfg_wdata;
        endcase
      end
      if (!out_stall && !emit_now) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cur_last_r <= in_last_vertex;
            replay_r   <= 1'b0;
            vx_r       <= in_x_coord;
            vy_r       <= in_y_coord;
            if (phase_r != PH_SECOND && phase_r != PH_RUN) begin
              first_x_r <= in_x_coord;
              first_y_r <= in_y_coord;
              prev_x_r  <= in_x_coord;
              prev_y_r  <= in_y_coord;
              kept_r    <= KEPT_W'(1);
              phase_r   <= PH_SECOND;
              state_r   <= ST_EMIT_FIRST;
            end else begin
              state_r <= ST_VISIT;
            end
          end
        end
        ST_EMIT_FIRST: begin
          if (slot_free) begin
            out_valid        <= 1'b1;
            out_x            <= first_x_r;
            out_y            <= first_y_r;
            out_contour_done <= 1'b0;
            out_kept_count   <= kept_r;
            state_r          <= ST_POST;
          end
        end
        ST_VISIT: begin
          if (vx_r == prev_x_r && vy_r == prev_y_r) begin
            state_r <= ST_POST;
          end else if (phase_r == PH_SECOND) begin
            dir_x_r  <= nx;
            dir_y_r  <= ny;
            prev_x_r <= vx_r;
            prev_y_r <= vy_r;
            phase_r  <= PH_RUN;
            state_r  <= ST_POST;
          end else begin
            step_r  <= SP_CXX;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          case (step_r)
            SP_DXX:  lc_r   <= acc_r[33:0];
            SP_MM:   ld_r   <= acc_r[33:0];
            SP_DOTX: mm_r   <= acc_r[31:0];
            SP_ADOT: dot_r  <= acc_r[34:0];
            SP_TT:   left_r <= acc_r[65:0];
            SP_RLO:  r1_r   <= acc_r[62:0];
            default: ;
          endcase
          acc_r  <= acc_nxt;
          step_r <= step_nxt;
          if (step_r == SP_RHI) begin
            state_r <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (merge) begin
            prev_x_r <= vx_r;
            prev_y_r <= vy_r;
            state_r  <= ST_POST;
          end else begin
            kept_r  <= kept_inc;
            dir_x_r <= cx;
            dir_y_r <= cy;
            state_r <= ST_EMIT_PREV;
          end
        end
        ST_EMIT_PREV: begin
          if (slot_free) begin
            out_valid        <= 1'b1;
            out_x            <= prev_x_r;
            out_y            <= prev_y_r;
            out_contour_done <= 1'b0;
            out_kept_count   <= kept_r;
            prev_x_r         <= vx_r;
            prev_y_r         <= vy_r;
            state_r          <= ST_POST;
          end
        end
        ST_POST: begin
          if (cur_last_r && !replay_r) begin
            vx_r     <= first_x_r;
            vy_r     <= first_y_r;
            replay_r <= 1'b1;
            state_r  <= ST_VISIT;
          end else if (cur_last_r) begin
            state_r <= ST_EMIT_END;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_EMIT_END: begin
          if (slot_free) begin
            out_valid        <= 1'b1;
            out_x            <= '0;
            out_y            <= '0;
            out_contour_done <= 1'b1;
            out_kept_count   <= kept_r;
            phase_r          <= PH_FIRST;
            kept_r           <= '0;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/cps_checker.sv */
// Port-level checks for the contour polyline simplifier unit.
// Depends on cps_pkg; bound to contour_polyline_simplifier_unit below.
module cps_checker
  import cps_pkg::*;
(
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [COORD_W-1:0]   out_x,
  input logic signed [COORD_W-1:0]   out_y,
  input logic                        out_contour_done,
  input logic        [KEPT_W-1:0]    out_kept_count
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_contour_done) && $stable(out_kept_count))
    else $error("stalled result changed");

  // Each vertex is worked on alone, so an input transfer is followed by a stall.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // The end result carries no coordinates.
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_contour_done |-> out_x == '0 && out_y == '0)
    else $error("end result with coordinates");

  // Every result counts at least the first vertex and never passes the limit.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kept_count != '0 && out_kept_count <= KEPT_MAX)
    else $error("kept count out of range");

endmodule

bind contour_polyline_simplifier_unit cps_checker u_cps_checker (.*);

/* tb/sv/cps_kept_point_check.sv */
// Checker for the contour polyline simplifier: predicts the kept points of each
// contour from the accepted vertices and register writes, and compares every result.
// Depends on cps_pkg for widths, register indexes, reset values and the phase type.
module cps_kept_point_check
  import cps_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic signed [COORD_W-1:0]   in_x_coord,
  input  logic signed [COORD_W-1:0]   in_y_coord,
  input  logic                        in_last_vertex,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [COORD_W-1:0]   out_x,
  input  logic signed [COORD_W-1:0]   out_y,
  input  logic                        out_contour_done,
  input  logic        [KEPT_W-1:0]    out_kept_count,
  input  logic                        cfg_we,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [CFG_W-1:0]     cfg_wdata,
  output int                          mismatch_count,
  output int                          pending_count
);

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      done;
    logic        [KEPT_W-1:0]  count;
  } kept_point_t;

  kept_point_t expected_points[$];

  logic signed [CFG_W-1:0]   cos_limit;
  logic        [CFG_W-1:0]   min_len;
  logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
  logic signed [DIFF_W-1:0]  dir_x, dir_y;
  phase_t                    phase;
  logic        [KEPT_W-1:0]  kept;

  function automatic logic [63:0] squared_length(longint dx, longint dy);
    return 64'(dx * dx + dy * dy);
  endfunction

  // The cosine test is done on squares so that no division or root is needed.
  function automatic bit corner_merges(longint sx, longint sy);
    longint       dx, dy, thr, dot;
    logic [63:0]  seg_sq, dir_sq, min_sq;
    logic [127:0] dot_abs, thr_sq, lhs, rhs;
    dx = dir_x;
    dy = dir_y;
    seg_sq = squared_length(sx, sy);
    dir_sq = squared_length(dx, dy);
    min_sq = 64'(min_len) * 64'(min_len);
    if (dir_sq == 0 || seg_sq == 0) return 1'b1;
    if (seg_sq < min_sq) return 1'b1;
    thr = cos_limit;
    dot = dx * sx + dy * sy;
    dot_abs = (dot < 0) ? -dot : dot;
    thr_sq = thr * thr;
    lhs = (dot_abs * dot_abs) << 30;
    rhs = thr_sq * dir_sq * seg_sq;
    if (thr >= 0) return (dot > 0) && (lhs > rhs);
    return (dot >= 0) || (lhs < rhs);
  endfunction

  function automatic void keep_point(logic signed [COORD_W-1:0] x,
                                     logic signed [COORD_W-1:0] y, logic done);
    kept_point_t p;
    p.x = x;
    p.y = y;
    p.done = done;
    p.count = kept;
    expected_points.push_back(p);
  endfunction

  function automatic void count_kept();
    if (kept < KEPT_MAX) kept = kept + 1'b1;
  endfunction

  function automatic void visit_vertex(logic signed [COORD_W-1:0] x,
                                       logic signed [COORD_W-1:0] y);
    longint sx, sy;
    if (x == prev_x && y == prev_y) return;
    if (phase == PH_SECOND) begin
      dir_x = x - first_x;
      dir_y = y - first_y;
      prev_x = x;
      prev_y = y;
      phase = PH_RUN;
      return;
    end
    sx = x - prev_x;
    sy = y - prev_y;
    if (!corner_merges(sx, sy)) begin
      count_kept();
      keep_point(prev_x, prev_y, 1'b0);
      dir_x = sx[DIFF_W-1:0];
      dir_y = sy[DIFF_W-1:0];
    end
    prev_x = x;
    prev_y = y;
  endfunction

  function automatic void take_vertex(logic signed [COORD_W-1:0] x,
                                      logic signed [COORD_W-1:0] y, logic last);
    if (phase != PH_SECOND && phase != PH_RUN) begin
      first_x = x;
      first_y = y;
      prev_x = x;
      prev_y = y;
      kept = '0;
      count_kept();
      keep_point(x, y, 1'b0);
      phase = PH_SECOND;
    end else begin
      visit_vertex(x, y);
    end
    // The closing vertex is replayed through the same test before the end result.
    if (last) begin
      visit_vertex(first_x, first_y);
      keep_point('0, '0, 1'b1);
      phase = PH_FIRST;
      kept = '0;
    end
  endfunction

  always @(posedge clk) begin
    kept_point_t want;
    if (!rst_n) begin
      cos_limit = COS_THRESHOLD_RST;
      min_len = MIN_LENGTH_RST;
      first_x = '0;
      first_y = '0;
      prev_x = '0;
      prev_y = '0;
      dir_x = '0;
      dir_y = '0;
      phase = PH_FIRST;
      kept = '0;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_COS_THRESHOLD) cos_limit = cfg_wdata;
        else if (cfg_index == CFG_MIN_LENGTH) min_len = cfg_wdata;
      end
      if (in_valid && !in_stall) take_vertex(in_x_coord, in_y_coord, in_last_vertex);
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected transfer x=%0d y=%0d done=%0d count=%0d", $time,
                     out_x, out_y, out_contour_done, out_kept_count);
        end else begin
          want = expected_points.pop_front();
          if (out_x !== want.x || out_y !== want.y || out_contour_done !== want.done ||
              out_kept_count !== want.count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected %0d,%0d done %0d count %0d, got %0d,%0d done %0d count %0d",
                       $time, want.x, want.y, want.done, want.count,
                       out_x, out_y, out_contour_done, out_kept_count);
          end
        end
      end
    end
    pending_count = expected_points.size();
  end

endmodule

/* tb/sv/tb_contour_polyline_simplifier_unit.sv */
// Top of the contour polyline simplifier testbench: clock, reset, vertex stimulus,
// register writes and result stalls, with the verdict taken from the checker.
// Depends on cps_pkg, contour_polyline_simplifier_unit and cps_kept_point_check.
module tb_contour_polyline_simplifier_unit;
  import cps_pkg::*;

  localparam int LIMIT_TIME    = 8_000_000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 48;
  localparam int WRAP_VERTICES = 12;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [COORD_W-1:0]   in_x_coord;
  logic signed [COORD_W-1:0]   in_y_coord;
  logic                        in_last_vertex;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [COORD_W-1:0]   out_x;
  logic signed [COORD_W-1:0]   out_y;
  logic                        out_contour_done;
  logic        [KEPT_W-1:0]    out_kept_count;
  logic                        cfg_we;
  logic        [CFG_IDX_W-1:0] cfg_index;
  logic        [CFG_W-1:0]     cfg_wdata;

  int mismatches;
  int pending;
  int burst_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  logic signed [COORD_W-1:0] cur_x = '0;
  logic signed [COORD_W-1:0] cur_y = '0;
  int step_x = 0;
  int step_y = 0;
  int cos_set [7] = '{31130, 32767, -32768, 0, -16384, 30000, 31130};
  int min_set [7] = '{0, 0, 0, 65535, 100, 2000, 64};

  always #5 clk = ~clk;

  contour_polyline_simplifier_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_x_coord       (in_x_coord),
    .in_y_coord       (in_y_coord),
    .in_last_vertex   (in_last_vertex),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_contour_done (out_contour_done),
    .out_kept_count   (out_kept_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  cps_kept_point_check kept_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_x_coord       (in_x_coord),
    .in_y_coord       (in_y_coord),
    .in_last_vertex   (in_last_vertex),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_contour_done (out_contour_done),
    .out_kept_count   (out_kept_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatches),
    .pending_count    (pending)
  );

  function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[COORD_W-1:0];
  endfunction

  // The sender works in bursts; a new burst may start after a random gap.
  task automatic send_vertex(input logic signed [COORD_W-1:0] vx,
                             input logic signed [COORD_W-1:0] vy, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_x_coord <= vx;
    in_y_coord <= vy;
    in_last_vertex <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic next_vertex(output logic signed [COORD_W-1:0] vx,
                             output logic signed [COORD_W-1:0] vy);
    int     pick;
    longint nx, ny;
    pick = $urandom_range(0, 99);
    nx = longint'(cur_x);
    ny = longint'(cur_y);
    if (pick >= 10 && pick < 25) begin
      nx = longint'($signed(16'($urandom)));
      ny = longint'($signed(16'($urandom)));
    end else if (pick >= 25 && pick < 32) begin
      nx = $urandom_range(0, 1) ? 32767 : -32768;
      ny = $urandom_range(0, 1) ? 32767 : -32768;
    end else if (pick >= 32 && pick < 65) begin
      step_x = int'($urandom_range(0, 600)) - 300;
      step_y = int'($urandom_range(0, 600)) - 300;
      nx = longint'(cur_x) + step_x;
      ny = longint'(cur_y) + step_y;
    end else if (pick >= 65) begin
      // Nearly straight continuation, so that merges happen often.
      nx = longint'(cur_x) + step_x + int'($urandom_range(0, 4)) - 2;
      ny = longint'(cur_y) + step_y + int'($urandom_range(0, 4)) - 2;
    end
    vx = clamp_coord(nx);
    vy = clamp_coord(ny);
    cur_x = vx;
    cur_y = vy;
  endtask

  task automatic random_contour(input int len);
    logic signed [COORD_W-1:0] vx, vy;
    for (int i = 0; i < len; i++) begin
      next_vertex(vx, vy);
      send_vertex(vx, vy, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int thr, input int mlen);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= CFG_COS_THRESHOLD;
    cfg_wdata <= CFG_W'(thr);
    @(posedge clk);
    cfg_index <= CFG_MIN_LENGTH;
    cfg_wdata <= CFG_W'(mlen);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    #(LIMIT_TIME);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int wide_x, wide_y, sent, len;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_x_coord <= '0;
    in_y_coord <= '0;
    in_last_vertex <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_COS_THRESHOLD;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // A contour of one vertex.
    send_vertex(COORD_W'(-32768), COORD_W'(32767), 1'b1);
    // Repeats, a straight run, a turn, the coordinate extremes, and a closing vertex
    // equal to the first one.
    send_vertex(COORD_W'(0), COORD_W'(0), 1'b0);
    send_vertex(COORD_W'(0), COORD_W'(0), 1'b0);
    send_vertex(COORD_W'(640), COORD_W'(0), 1'b0);
    send_vertex(COORD_W'(1280), COORD_W'(0), 1'b0);
    send_vertex(COORD_W'(1280), COORD_W'(0), 1'b0);
    send_vertex(COORD_W'(1280), COORD_W'(640), 1'b0);
    send_vertex(COORD_W'(32767), COORD_W'(32767), 1'b0);
    send_vertex(COORD_W'(-32768), COORD_W'(-32768), 1'b0);
    send_vertex(COORD_W'(-32768), COORD_W'(32767), 1'b0);
    send_vertex(COORD_W'(32767), COORD_W'(-32768), 1'b0);
    send_vertex(COORD_W'(0), COORD_W'(0), 1'b1);
    // A last vertex that repeats the first one.
    send_vertex(COORD_W'(5), COORD_W'(-7), 1'b0);
    send_vertex(COORD_W'(5), COORD_W'(-7), 1'b1);
    // Two vertices, so the contour closes while only the start direction is known.
    send_vertex(COORD_W'(100), COORD_W'(200), 1'b0);
    send_vertex(COORD_W'(-300), COORD_W'(400), 1'b1);
    // A reversal on a diagonal.
    send_vertex(COORD_W'(-1), COORD_W'(-1), 1'b0);
    send_vertex(COORD_W'(1), COORD_W'(1), 1'b0);
    send_vertex(COORD_W'(3), COORD_W'(3), 1'b0);
    send_vertex(COORD_W'(2), COORD_W'(2), 1'b0);
    send_vertex(COORD_W'(-5), COORD_W'(5), 1'b0);
    send_vertex(COORD_W'(-1), COORD_W'(2), 1'b1);

    // The receiver holds off while a long contour keeps coming in.
    configure(32767, 0);
    hold_req = 1'b1;
    random_contour(24);

    // Every segment reverses, so every vertex is kept.
    for (int i = 0; i < WRAP_VERTICES; i++) begin
      wide_x = 1000 + int'($urandom_range(0, 500));
      if (i % 2 == 0) wide_x = -wide_x;
      wide_y = int'($urandom_range(0, 1000)) - 500;
      send_vertex(clamp_coord(longint'(wide_x)), clamp_coord(longint'(wide_y)),
                  i == WRAP_VERTICES - 1);
    end

    for (int p = 0; p < 7; p++) begin
      configure(cos_set[p], min_set[p]);
      sent = 0;
      while (sent < 5) begin
        len = $urandom_range(1, 9);
        random_contour(len);
        sent += len;
      end
    end

    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
